>>> hw/rtl/lxrg_pkg.sv
// Shared constants, types and helpers for the lagged XOR random generator.
// Used by every other source file of the project; depends on nothing.
package lxrg_pkg;

    localparam int TABLE_SIZE = 250;
    localparam int INDEX_WRAP = 249;
    localparam int LAG_START  = 103;

    localparam int IDX_W   = 8;
    localparam int WORD_W  = 31;
    localparam int DATA_W  = 32;
    localparam int FRAC_W  = 16;
    localparam int HALF_W  = 16;

    // One remainder step per bit of the drawn word.
    localparam int REM_STEPS = WORD_W;
    localparam int STEP_W    = $clog2(REM_STEPS);

    localparam logic [DATA_W-1:0] LCG_MUL = 32'h41c6_4e6d;
    localparam logic [DATA_W-1:0] LCG_INC = 32'd12345;

    typedef enum logic [1:0] {
        OP_SEED   = 2'd0,
        OP_RAW    = 2'd1,
        OP_RANGED = 2'd2,
        OP_FRAC   = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED_A,
        ST_SEED_B,
        ST_DRAW,
        ST_REM,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  addr;
        logic [WORD_W-1:0] data;
    } t_tbl_wr;

    // Advance an index by one, wrapping to zero on reaching INDEX_WRAP.
    function automatic logic [IDX_W-1:0] next_index(input logic [IDX_W-1:0] idx);
        logic [IDX_W:0]   sum;
        logic [IDX_W-1:0] nxt;
        sum = {1'b0, idx} + {{IDX_W{1'b0}}, 1'b1};
        nxt = sum[IDX_W-1:0];
        return ({1'b0, nxt} >= (IDX_W + 1)'(INDEX_WRAP)) ? '0 : nxt;
    endfunction

endpackage

>>> hw/rtl/lxrg_table.sv
// Word table of the generator: one write port, two registered read ports.
// Per-entry valid bits make unwritten entries read as zero after reset.
// Depends on lxrg_pkg.
module lxrg_table (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  lxrg_pkg::t_tbl_wr               i_wr,
    input  logic [lxrg_pkg::IDX_W-1:0]      i_rd_addr_a,
    input  logic [lxrg_pkg::IDX_W-1:0]      i_rd_addr_b,
    output logic [lxrg_pkg::WORD_W-1:0]     o_rd_data_a,
    output logic [lxrg_pkg::WORD_W-1:0]     o_rd_data_b
);

    logic [lxrg_pkg::WORD_W-1:0] r_mem [lxrg_pkg::TABLE_SIZE];
    logic [lxrg_pkg::TABLE_SIZE-1:0] r_valid;
    logic [lxrg_pkg::WORD_W-1:0] r_rd_a;
    logic [lxrg_pkg::WORD_W-1:0] r_rd_b;
    logic                        r_vld_a;
    logic                        r_vld_b;

    logic wr_in_table;
    logic rd_a_in_table;
    logic rd_b_in_table;

    assign wr_in_table   = {1'b0, i_wr.addr}
                           < (lxrg_pkg::IDX_W + 1)'(lxrg_pkg::TABLE_SIZE);
    assign rd_a_in_table = {1'b0, i_rd_addr_a}
                           < (lxrg_pkg::IDX_W + 1)'(lxrg_pkg::TABLE_SIZE);
    assign rd_b_in_table = {1'b0, i_rd_addr_b}
                           < (lxrg_pkg::IDX_W + 1)'(lxrg_pkg::TABLE_SIZE);

    always_ff @(posedge i_clk) begin
        if (i_wr.we && wr_in_table) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_a <= r_mem[i_rd_addr_a];
        r_rd_b <= r_mem[i_rd_addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else begin
            if (i_wr.we && wr_in_table) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
            r_vld_a <= rd_a_in_table && r_valid[i_rd_addr_a];
            r_vld_b <= rd_b_in_table && r_valid[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_vld_a ? r_rd_a : '0;
    assign o_rd_data_b = r_vld_b ? r_rd_b : '0;

endmodule

>>> hw/rtl/lagged_xor_random_generator_top.sv
// Top level of the lagged XOR random generator: sequencer, seed multiplier
// and bit-serial remainder unit. Depends on lxrg_pkg and lxrg_table.
//
// R250-style generator over a table of 250 words of 31 bits. A seed request
// refills the whole table with a two-step linear congruential sequence from
// one shared 32x32 multiplier, writing each entry in the seed-B state, and
// returns nothing. A raw or fraction draw reads both lagged entries in the
// accepting cycle and goes through the draw and done states to the output
// register. A ranged draw with a nonzero span also runs the remainder of the
// drawn word by the span magnitude through one shared subtract-and-compare
// unit, one bit per cycle over the 31 bits of the word. The block takes one
// request at a time; a finished result waits in the output register, so the
// next request may be accepted before the previous result is taken.
module lagged_xor_random_generator_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [1:0]                         i_opcode,
    input  logic [lxrg_pkg::DATA_W-1:0]        i_seed_value,
    input  logic signed [lxrg_pkg::DATA_W-1:0] i_range_low,
    input  logic signed [lxrg_pkg::DATA_W-1:0] i_range_high,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [lxrg_pkg::WORD_W-1:0]        o_raw_value,
    output logic signed [lxrg_pkg::DATA_W-1:0] o_ranged_value,
    output logic [lxrg_pkg::FRAC_W-1:0]        o_fraction,
    output logic                               o_span_error
);

    lxrg_pkg::t_state            r_state, n_state;
    lxrg_pkg::t_opcode           r_op, n_op;
    logic [lxrg_pkg::DATA_W-1:0] r_lcg, n_lcg;
    logic [lxrg_pkg::HALF_W-1:0] r_hi, n_hi;
    logic [lxrg_pkg::DATA_W-1:0] r_lo, n_lo;
    logic [lxrg_pkg::DATA_W-1:0] r_span, n_span;
    logic [lxrg_pkg::IDX_W-1:0]  r_cnt, n_cnt;
    logic [lxrg_pkg::IDX_W-1:0]  r_widx, n_widx;
    logic [lxrg_pkg::IDX_W-1:0]  r_lidx, n_lidx;
    logic [lxrg_pkg::WORD_W-1:0] r_raw, n_raw;
    logic [lxrg_pkg::DATA_W-1:0] r_mag, n_mag;
    logic [lxrg_pkg::DATA_W-1:0] r_rem, n_rem;
    logic [lxrg_pkg::WORD_W-1:0] r_div, n_div;
    logic [lxrg_pkg::STEP_W-1:0] r_step, n_step;
    logic                        r_err, n_err;

    logic                        r_out_valid, n_out_valid;
    logic [lxrg_pkg::WORD_W-1:0] r_out_raw, n_out_raw;
    logic [lxrg_pkg::DATA_W-1:0] r_out_ranged, n_out_ranged;
    logic [lxrg_pkg::FRAC_W-1:0] r_out_frac, n_out_frac;
    logic                        r_out_err, n_out_err;

    lxrg_pkg::t_tbl_wr           tbl_wr;
    logic [lxrg_pkg::WORD_W-1:0] rd_data_a;
    logic [lxrg_pkg::WORD_W-1:0] rd_data_b;
    logic [lxrg_pkg::DATA_W-1:0] lcg_next;
    logic [lxrg_pkg::WORD_W-1:0] draw_value;
    logic [lxrg_pkg::DATA_W-1:0] span_mag;
    logic [lxrg_pkg::DATA_W:0]   rem_shift;
    logic [lxrg_pkg::DATA_W:0]   rem_diff;

    lxrg_table u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (tbl_wr),
        .i_rd_addr_a (r_widx),
        .i_rd_addr_b (r_lidx),
        .o_rd_data_a (rd_data_a),
        .o_rd_data_b (rd_data_b)
    );

    // The one multiplier, shared by both steps of every seed entry.
    assign lcg_next   = r_lcg * lxrg_pkg::LCG_MUL + lxrg_pkg::LCG_INC;
    assign draw_value = rd_data_a ^ rd_data_b;
    assign span_mag   = r_span[lxrg_pkg::DATA_W-1] ? (~r_span + 32'd1) : r_span;
    assign rem_shift  = {r_rem, r_div[lxrg_pkg::WORD_W-1]};
    assign rem_diff   = rem_shift - {1'b0, r_mag};

    assign o_ready        = (r_state == lxrg_pkg::ST_IDLE);
    assign o_valid        = r_out_valid;
    assign o_raw_value    = r_out_raw;
    assign o_ranged_value = r_out_ranged;
    assign o_fraction     = r_out_frac;
    assign o_span_error   = r_out_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lxrg_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_widx      <= '0;
            r_lidx      <= lxrg_pkg::IDX_W'(lxrg_pkg::LAG_START);
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_widx      <= n_widx;
            r_lidx      <= n_lidx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_lcg        <= n_lcg;
        r_hi         <= n_hi;
        r_lo         <= n_lo;
        r_span       <= n_span;
        r_cnt        <= n_cnt;
        r_raw        <= n_raw;
        r_mag        <= n_mag;
        r_rem        <= n_rem;
        r_div        <= n_div;
        r_step       <= n_step;
        r_err        <= n_err;
        r_out_raw    <= n_out_raw;
        r_out_ranged <= n_out_ranged;
        r_out_frac   <= n_out_frac;
        r_out_err    <= n_out_err;
    end

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_lcg        = r_lcg;
        n_hi         = r_hi;
        n_lo         = r_lo;
        n_span       = r_span;
        n_cnt        = r_cnt;
        n_widx       = r_widx;
        n_lidx       = r_lidx;
        n_raw        = r_raw;
        n_mag        = r_mag;
        n_rem        = r_rem;
        n_div        = r_div;
        n_step       = r_step;
        n_err        = r_err;
        n_out_valid  = r_out_valid;
        n_out_raw    = r_out_raw;
        n_out_ranged = r_out_ranged;
        n_out_frac   = r_out_frac;
        n_out_err    = r_out_err;
        tbl_wr       = '0;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            lxrg_pkg::ST_IDLE: begin
                // The table read ports sample both indices in this cycle too.
                if (i_valid) begin
                    n_op   = lxrg_pkg::t_opcode'(i_opcode);
                    n_lcg  = i_seed_value;
                    n_lo   = i_range_low;
                    n_span = i_range_high - i_range_low;
                    n_cnt  = '0;
                    if (lxrg_pkg::t_opcode'(i_opcode) == lxrg_pkg::OP_SEED) begin
                        n_state = lxrg_pkg::ST_SEED_A;
                    end else begin
                        n_state = lxrg_pkg::ST_DRAW;
                    end
                end
            end
            lxrg_pkg::ST_SEED_A: begin
                n_lcg   = lcg_next;
                n_hi    = lcg_next[lxrg_pkg::DATA_W-1:lxrg_pkg::HALF_W];
                n_state = lxrg_pkg::ST_SEED_B;
            end
            lxrg_pkg::ST_SEED_B: begin
                // The masked high bits have clear low halves, so the sum is
                // a plain concatenation.
                n_lcg        = lcg_next;
                tbl_wr.we    = 1'b1;
                tbl_wr.addr  = r_cnt;
                tbl_wr.data  = {lcg_next[lxrg_pkg::WORD_W-1:lxrg_pkg::HALF_W], r_hi};
                if (r_cnt == lxrg_pkg::IDX_W'(lxrg_pkg::TABLE_SIZE - 1)) begin
                    n_widx  = '0;
                    n_lidx  = lxrg_pkg::IDX_W'(lxrg_pkg::LAG_START);
                    n_state = lxrg_pkg::ST_IDLE;
                end else begin
                    n_cnt   = r_cnt + 1'b1;
                    n_state = lxrg_pkg::ST_SEED_A;
                end
            end
            lxrg_pkg::ST_DRAW: begin
                tbl_wr.we   = 1'b1;
                tbl_wr.addr = r_widx;
                tbl_wr.data = draw_value;
                n_widx      = lxrg_pkg::next_index(r_widx);
                n_lidx      = lxrg_pkg::next_index(r_lidx);
                n_raw       = draw_value;
                n_mag       = span_mag;
                n_rem       = '0;
                n_div       = draw_value;
                n_step      = '0;
                n_err       = (r_op == lxrg_pkg::OP_RANGED) && (span_mag == '0);
                if ((r_op == lxrg_pkg::OP_RANGED) && (span_mag != '0)) begin
                    n_state = lxrg_pkg::ST_REM;
                end else begin
                    n_state = lxrg_pkg::ST_DONE;
                end
            end
            lxrg_pkg::ST_REM: begin
                // Restoring remainder, one dividend bit per cycle, MSB first.
                if (!rem_diff[lxrg_pkg::DATA_W]) begin
                    n_rem = rem_diff[lxrg_pkg::DATA_W-1:0];
                end else begin
                    n_rem = rem_shift[lxrg_pkg::DATA_W-1:0];
                end
                n_div  = {r_div[lxrg_pkg::WORD_W-2:0], 1'b0};
                n_step = r_step + 1'b1;
                if (r_step == lxrg_pkg::STEP_W'(lxrg_pkg::REM_STEPS - 1)) begin
                    n_state = lxrg_pkg::ST_DONE;
                end
            end
            lxrg_pkg::ST_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_raw   = r_raw;
                    n_out_err   = r_err;
                    if (r_op == lxrg_pkg::OP_RANGED) begin
                        n_out_ranged = r_err ? r_lo : (r_lo + r_rem);
                    end else begin
                        n_out_ranged = '0;
                    end
                    if (r_op == lxrg_pkg::OP_FRAC) begin
                        n_out_frac = r_raw[lxrg_pkg::FRAC_W-1:0];
                    end else begin
                        n_out_frac = '0;
                    end
                    n_state = lxrg_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lxrg_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> hw/rtl/lxrg_checker.sv
// Port-level checks for the lagged XOR random generator top level.
// Depends on lxrg_pkg and lagged_xor_random_generator_top; attached to it by bind.
module lxrg_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_valid,
    input logic                               i_ready,
    input logic [lxrg_pkg::WORD_W-1:0]        o_raw_value,
    input logic signed [lxrg_pkg::DATA_W-1:0] o_ranged_value,
    input logic [lxrg_pkg::FRAC_W-1:0]        o_fraction,
    input logic                               o_span_error
);

    // A result held back by the consumer keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_raw_value)
            && $stable(o_ranged_value) && $stable(o_fraction))
        else $error("result changed while stalled");

    // A nonzero fraction is always the low half of the drawn word.
    a_frac_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_fraction != '0) |-> o_fraction == o_raw_value[lxrg_pkg::FRAC_W-1:0])
        else $error("fraction does not match drawn word");

    // A span error only comes from a ranged request, which carries no fraction.
    a_err_no_frac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_span_error |-> o_fraction == '0)
        else $error("span error with a fraction");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind lagged_xor_random_generator_top lxrg_checker u_lxrg_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_raw_value    (o_raw_value),
    .o_ranged_value (o_ranged_value),
    .o_fraction     (o_fraction),
    .o_span_error   (o_span_error)
);

>>> sim/lagged_xor_random_generator_top_tb.sv
// Self-checking testbench for lagged_xor_random_generator_top: random request
// traffic against a behavioural model of the lagged XOR table and its LCG seeding.
// Depends on lxrg_pkg and the generator RTL only.
module lagged_xor_random_generator_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] HIGH_MASK     = 32'h7fff_0000;
    localparam int          SETTLE_CYCLES = 600;
    localparam int          HOLD_CYCLES   = 400;

    typedef struct packed {
        lxrg_pkg::t_opcode op;
        logic [31:0]       seed;
        logic [31:0]       lo;
        logic [31:0]       hi;
        logic [7:0]        gap;
    } t_request;

    typedef struct packed {
        logic [lxrg_pkg::WORD_W-1:0] raw;
        logic [31:0]                 ranged;
        logic [lxrg_pkg::FRAC_W-1:0] frac;
        logic                        span_err;
    } t_draw;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic out_ready = 1'b0;
    logic req_fire = 1'b0;
    logic hold_off = 1'b0;
    t_request offered = '0;

    logic                               o_ready;
    logic                               o_valid;
    logic [lxrg_pkg::WORD_W-1:0]        o_raw_value;
    logic signed [lxrg_pkg::DATA_W-1:0] o_ranged_value;
    logic [lxrg_pkg::FRAC_W-1:0]        o_fraction;
    logic                               o_span_error;

    t_request pending[$];
    t_draw    expected_draws[$];
    int       items_queued = 0;
    int       requests_taken = 0;
    int       mismatch_count = 0;
    int       send_calm = 0;
    int       stall_left = 0;
    int       calm_left = 0;

    // Model state: word table and the two lagged indices.
    logic [lxrg_pkg::WORD_W-1:0] gen_table [lxrg_pkg::TABLE_SIZE];
    logic [7:0]                  gen_wr = 8'd0;
    logic [7:0]                  gen_lag = 8'(lxrg_pkg::LAG_START);

    lagged_xor_random_generator_top i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_valid        (in_valid),
        .o_ready        (o_ready),
        .i_opcode       (offered.op),
        .i_seed_value   (offered.seed),
        .i_range_low    (offered.lo),
        .i_range_high   (offered.hi),
        .o_valid        (o_valid),
        .i_ready        (out_ready),
        .o_raw_value    (o_raw_value),
        .o_ranged_value (o_ranged_value),
        .o_fraction     (o_fraction),
        .o_span_error   (o_span_error)
    );

    always begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] bump_index(input logic [7:0] idx);
        logic [7:0] nxt;
        nxt = idx + 8'd1;
        return (nxt >= lxrg_pkg::INDEX_WRAP) ? 8'd0 : nxt;
    endfunction

    // Each entry takes the high half of one LCG step plus bits 30..16 of the next.
    task automatic seed_generator(input logic [31:0] seed);
        logic [31:0] v;
        logic [31:0] upper;
        v = seed;
        for (int i = 0; i < lxrg_pkg::TABLE_SIZE; i++) begin
            v = v * lxrg_pkg::LCG_MUL + lxrg_pkg::LCG_INC;
            upper = v >> 16;
            v = v * lxrg_pkg::LCG_MUL + lxrg_pkg::LCG_INC;
            gen_table[i] = lxrg_pkg::WORD_W'(upper + (v & HIGH_MASK));
        end
        gen_wr = 8'd0;
        gen_lag = 8'(lxrg_pkg::LAG_START);
    endtask

    task automatic predict_draw(input t_request r, output t_draw d);
        logic [31:0] span;
        logic [31:0] mag;
        d = '0;
        d.raw = gen_table[gen_wr] ^ gen_table[gen_lag];
        gen_table[gen_wr] = d.raw;
        gen_wr = bump_index(gen_wr);
        gen_lag = bump_index(gen_lag);
        case (r.op)
            lxrg_pkg::OP_RANGED: begin
                // The span wraps at 32 bits before its magnitude is taken.
                span = r.hi - r.lo;
                mag = span[31] ? (32'd0 - span) : span;
                if (mag == 32'd0) begin
                    d.ranged = r.lo;
                    d.span_err = 1'b1;
                end else begin
                    d.ranged = r.lo + ({1'b0, d.raw} % mag);
                end
            end
            lxrg_pkg::OP_FRAC: d.frac = d.raw[lxrg_pkg::FRAC_W-1:0];
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on %s: got %h, expected %h", what, got, want);
        mismatch_count++;
    endtask

    task automatic queue_request(input lxrg_pkg::t_opcode op, input logic [31:0] seed,
                                 input logic [31:0] lo, input logic [31:0] hi);
        t_request r;
        r.op = op;
        r.seed = seed;
        r.lo = lo;
        r.hi = hi;
        if (send_calm != 0) begin
            send_calm--;
            r.gap = 8'd0;
        end else if ($urandom_range(0, 9) == 0) begin
            send_calm = $urandom_range(20, 60);
            r.gap = 8'd0;
        end else begin
            r.gap = 8'(pick_idle());
        end
        pending.push_back(r);
        items_queued++;
    endtask

    task automatic queue_random_draw();
        lxrg_pkg::t_opcode op;
        logic [31:0]       lo;
        logic [31:0]       hi;
        op = lxrg_pkg::t_opcode'($urandom_range(1, 3));
        lo = $urandom;
        hi = $urandom;
        case ($urandom_range(0, 5))
            2, 3: begin
                // Narrow spans, either direction, so the remainder is small.
                if ($urandom_range(0, 1) == 1) begin
                    hi = lo + $urandom_range(1, 1000);
                end else begin
                    hi = lo - $urandom_range(1, 1000);
                end
            end
            4: hi = lo;
            5: begin
                lo = $urandom_range(0, 200) - 100;
                hi = $urandom_range(0, 200) - 100;
            end
            default: ;
        endcase
        queue_request(op, $urandom, lo, hi);
    endtask

    // Request side: a new request is offered only once the previous one has gone.
    always @(negedge clk) begin
        t_request nxt;
        if (rst_n && (!in_valid || req_fire)) begin
            if (offered.gap != 8'd0 && in_valid) begin
                in_valid <= 1'b0;
                offered.gap <= offered.gap - 8'd1;
            end else if (!in_valid && offered.gap != 8'd0) begin
                offered.gap <= offered.gap - 8'd1;
            end else if (pending.size() != 0) begin
                nxt = pending.pop_front();
                offered <= nxt;
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result side: random stalls, calm stretches and one long hold-off.
    always @(negedge clk) begin
        if (!rst_n || hold_off) begin
            out_ready <= 1'b0;
        end else if (stall_left != 0) begin
            out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            out_ready <= 1'b1;
            if (calm_left != 0) begin
                calm_left <= calm_left - 1;
            end else if ($urandom_range(0, 9) == 0) begin
                calm_left <= $urandom_range(20, 80);
            end else begin
                stall_left <= pick_idle();
            end
        end
    end

    always @(posedge clk) begin
        t_draw want;
        t_draw next_draw;
        if (rst_n) begin
            if (o_valid && out_ready) begin
                if (expected_draws.size() == 0) begin
                    report_mismatch("result with no request outstanding",
                                    {1'b0, o_raw_value}, 32'd0);
                end else begin
                    want = expected_draws.pop_front();
                    if (o_raw_value !== want.raw) begin
                        report_mismatch("raw_value", {1'b0, o_raw_value}, {1'b0, want.raw});
                    end
                    if (o_ranged_value !== want.ranged) begin
                        report_mismatch("ranged_value", o_ranged_value, want.ranged);
                    end
                    if (o_fraction !== want.frac) begin
                        report_mismatch("fraction", {16'd0, o_fraction}, {16'd0, want.frac});
                    end
                    if (o_span_error !== want.span_err) begin
                        report_mismatch("span_error", {31'd0, o_span_error},
                                        {31'd0, want.span_err});
                    end
                end
            end
            req_fire <= in_valid && o_ready;
            if (in_valid && o_ready) begin
                requests_taken++;
                if (offered.op == lxrg_pkg::OP_SEED) begin
                    seed_generator(offered.seed);
                end else begin
                    predict_draw(offered, next_draw);
                    expected_draws.push_back(next_draw);
                end
            end
        end
    end

    // Hold the result side off long enough for the block to back up its input.
    initial begin
        while (requests_taken < 60) begin
            @(posedge clk);
        end
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
    end

    initial begin
        #4_000_000;
        $display("lagged_xor_random_generator_top_tb NOT OK");
        $finish;
    end

    initial begin
        // The model table starts cleared, as the block's table does after reset.
        for (int i = 0; i < lxrg_pkg::TABLE_SIZE; i++) begin
            gen_table[i] = '0;
        end

        // Draws on the cleared table must all come back with a zero raw value.
        queue_request(lxrg_pkg::OP_RAW, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        queue_request(lxrg_pkg::OP_RANGED, 32'd0, -32'sd5, 32'sd10);
        queue_request(lxrg_pkg::OP_FRAC, 32'd0, 32'd0, 32'd0);
        queue_request(lxrg_pkg::OP_SEED, 32'd0, 32'hffff_ffff, 32'hffff_ffff);
        queue_request(lxrg_pkg::OP_RAW, 32'd0, 32'd0, 32'd0);
        queue_request(lxrg_pkg::OP_FRAC, 32'hffff_ffff, 32'd0, 32'd0);
        queue_request(lxrg_pkg::OP_RANGED, 32'd0, 32'h1234_5678, 32'h1234_5678);
        queue_request(lxrg_pkg::OP_RANGED, 32'd0, 32'sd100, -32'sd100);
        // A span of minus two to the 31 keeps its full magnitude.
        queue_request(lxrg_pkg::OP_RANGED, 32'd0, 32'h0000_0000, 32'h8000_0000);
        queue_request(lxrg_pkg::OP_RANGED, 32'd0, 32'h8000_0000, 32'h7fff_ffff);
        queue_request(lxrg_pkg::OP_RANGED, 32'd0, 32'h7fff_fff0,
                      32'h7fff_fff0 + 32'h7fff_ffff);
        queue_request(lxrg_pkg::OP_RANGED, 32'd0, 32'h7fff_ffff, 32'h8000_0000);
        queue_request(lxrg_pkg::OP_RANGED, 32'd0, 32'h8000_0000, 32'h8000_0000);
        queue_request(lxrg_pkg::OP_RANGED, 32'd0, 32'hffff_ffff, 32'h0000_0000);
        queue_request(lxrg_pkg::OP_SEED, 32'hffff_ffff, 32'd0, 32'd0);
        queue_request(lxrg_pkg::OP_RAW, 32'd0, 32'd0, 32'd0);
        queue_request(lxrg_pkg::OP_FRAC, 32'd0, 32'd0, 32'd0);
        queue_request(lxrg_pkg::OP_SEED, 32'ha5a5_5a5a, 32'd0, 32'd0);
        queue_request(lxrg_pkg::OP_RANGED, 32'd0, 32'h8000_0000, 32'h7fff_ffff + 32'd1);
        queue_request(lxrg_pkg::OP_RANGED, 32'hffff_ffff, 32'sd1, 32'sd0);

        // One long run after a seed carries both indices through their wrap.
        queue_request(lxrg_pkg::OP_SEED, $urandom, $urandom, $urandom);
        repeat (260) queue_random_draw();
        repeat (130) begin
            if ($urandom_range(0, 14) == 0) begin
                queue_request(lxrg_pkg::OP_SEED, $urandom, $urandom, $urandom);
            end else begin
                queue_random_draw();
            end
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (requests_taken != items_queued) begin
            @(negedge clk);
        end
        while (expected_draws.size() != 0) begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (mismatch_count == 0) begin
            $display("lagged_xor_random_generator_top_tb OK");
        end else begin
            $display("lagged_xor_random_generator_top_tb NOT OK");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/lxrg_pkg.sv
hw/rtl/lxrg_table.sv
hw/rtl/lagged_xor_random_generator_top.sv
hw/rtl/lxrg_checker.sv
sim/lagged_xor_random_generator_top_tb.sv
